>>> sv/rfc_pkg.sv
// Package for the read response frame checker.
// Holds the beat structs, status and register index codes, FSM state type and CRC step.
// No dependencies.
package rfc_pkg;

   // Result status codes
   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_SHORT     = 3'd1;
   localparam logic [2:0] STATUS_COUNT_BAD = 3'd2;
   localparam logic [2:0] STATUS_CRC_BAD   = 3'd3;
   localparam logic [2:0] STATUS_MISMATCH  = 3'd4;
   localparam logic [2:0] STATUS_TOO_MANY  = 3'd5;

   // Configuration register indexes
   localparam logic [1:0] CSR_SLAVE_ADDRESS = 2'd0;
   localparam logic [1:0] CSR_FUNCTION_CODE = 2'd1;
   localparam logic [1:0] CSR_MAX_REGISTERS = 2'd2;

   // Frame constants
   localparam logic [15:0] CRC_START      = 16'hFFFF;
   localparam logic [15:0] CRC_POLY       = 16'hA001;
   localparam logic [9:0]  FRAME_OVERHEAD = 10'd5;
   localparam logic [9:0]  LENGTH_MAX     = 10'd1023;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [5:0]  reg_total;
      logic [4:0]  register_index;
      logic [15:0] register_value;
      logic        value_valid;
      logic        run_last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_EMIT
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic byte_en;   // take one frame byte
      logic check_en;  // evaluate frame, clear per-frame state
      logic load_en;   // load next result into output register
   } ctl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic slot_free; // output register empty or being taken
      logic single;    // error or zero-count frame: one result
      logic run_done;  // current result is the last of the run
   } dp_status_type;

   // Reflected CRC-16 over one byte, eight shift steps
   function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

>>> sv/rfc_ctrl.sv
// Controller FSM for the read response frame checker.
// Sequences byte intake, frame check and result emission. Depends on rfc_pkg.
module rfc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_frame_end,
   output logic                   req_stall,
   input  rfc_pkg::dp_status_type dp_status,
   output rfc_pkg::ctl_cmd_type   cmd
);

   rfc_pkg::state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rfc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_stall    = 1'b1;
      unique case (state_ff)
         rfc_pkg::ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.byte_en = req_valid;
            if (req_valid && req_frame_end) begin
               state_in = rfc_pkg::ST_CHECK;
            end
         end
         rfc_pkg::ST_CHECK: begin
            cmd.check_en = 1'b1;
            state_in     = rfc_pkg::ST_EMIT;
         end
         rfc_pkg::ST_EMIT: begin
            // load a result whenever the output register can take it
            if (dp_status.slot_free) begin
               cmd.load_en = 1'b1;
               if (dp_status.single || dp_status.run_done) begin
                  state_in = rfc_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = rfc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> sv/rfc_datapath.sv
// Datapath for the read response frame checker: frame state, CRC, register store,
// configuration registers, checks and the output register. Depends on rfc_pkg.
module rfc_datapath #(
   parameter int MAX_REGS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rfc_pkg::req_type       req_data,
   input  rfc_pkg::ctl_cmd_type   cmd,
   output rfc_pkg::dp_status_type dp_status,
   input  logic                   csr_wr_en,
   input  logic [1:0]             csr_addr,
   input  logic [7:0]             csr_wr_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rfc_pkg::rsp_type       rsp_data
);

   localparam int AW = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
   localparam logic [8:0] SlotLimit = 9'(MAX_REGS);
   localparam logic [6:0] RegsLimit = 7'(MAX_REGS);

   // configuration
   logic [7:0] slave_address_ff;
   logic [7:0] function_code_ff;
   logic [5:0] max_registers_ff;

   // per-frame state
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  delay0_ff, delay1_ff;
   logic [9:0]  length_ff, length_in;
   logic [7:0]  address_ff, function_ff, count_byte_ff, high_ff;

   // emission state
   logic [2:0]  status_ff, status_in;
   logic [5:0]  count_ff;
   logic [5:0]  k_ff, k_next;
   logic        rsp_valid_ff;
   rfc_pkg::rsp_type rsp_data_ff;

   // register store
   logic [15:0] store_mem [MAX_REGS];
   logic [15:0] rd_data_ff;
   logic        wr_en;
   logic [8:0]  wr_slot;
   logic        rd_en;
   logic [AW-1:0] rd_addr;

   logic [6:0]  count_full;
   logic [6:0]  limit;
   logic [15:0] received;

   // Configuration writes; indexes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         slave_address_ff <= 8'd1;
         function_code_ff <= 8'd3;
         max_registers_ff <= 6'd32;
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            rfc_pkg::CSR_SLAVE_ADDRESS: slave_address_ff <= csr_wr_data;
            rfc_pkg::CSR_FUNCTION_CODE: function_code_ff <= csr_wr_data;
            rfc_pkg::CSR_MAX_REGISTERS: max_registers_ff <= csr_wr_data[5:0];
            default: ;
         endcase
      end
   end

   // Next CRC and saturating length for an incoming byte
   always_comb begin
      crc_in = crc_ff;
      if (length_ff >= 10'd2) begin
         crc_in = rfc_pkg::crc16_step(crc_ff, delay1_ff);
      end
      length_in = (length_ff < rfc_pkg::LENGTH_MAX) ? length_ff + 10'd1 : length_ff;
   end

   // Store write on the low byte of each word that fits in the store
   assign wr_slot = length_ff[9:1] - 9'd2;
   assign wr_en   = cmd.byte_en && (length_ff >= 10'd4) && !length_ff[0]
                    && (wr_slot < SlotLimit);

   // Frame state: capture header, words and delay line; clear after the check
   always_ff @(posedge clock) begin
      if (reset || cmd.check_en) begin
         crc_ff        <= rfc_pkg::CRC_START;
         delay0_ff     <= '0;
         delay1_ff     <= '0;
         length_ff     <= '0;
         address_ff    <= '0;
         function_ff   <= '0;
         count_byte_ff <= '0;
         high_ff       <= '0;
      end else if (cmd.byte_en) begin
         crc_ff    <= crc_in;
         delay1_ff <= delay0_ff;
         delay0_ff <= req_data.data_byte;
         length_ff <= length_in;
         priority if (length_ff == 10'd0) begin
            address_ff <= req_data.data_byte;
         end else if (length_ff == 10'd1) begin
            function_ff <= req_data.data_byte;
         end else if (length_ff == 10'd2) begin
            count_byte_ff <= req_data.data_byte;
         end else if (length_ff[0]) begin
            high_ff <= req_data.data_byte;
         end else begin
            // low byte of a word goes to the store
         end
      end
   end

   // Register store memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_slot[AW-1:0]] <= {high_ff, req_data.data_byte};
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   // Frame checks, first failure wins
   assign received   = {delay0_ff, delay1_ff};
   assign count_full = count_byte_ff[7:1];
   assign limit      = ({1'b0, max_registers_ff} > RegsLimit) ? RegsLimit
                                                              : {1'b0, max_registers_ff};
   always_comb begin
      priority if (length_ff < rfc_pkg::FRAME_OVERHEAD || slave_address_ff == 8'd0) begin
         status_in = rfc_pkg::STATUS_SHORT;
      end else if (crc_ff != received) begin
         status_in = rfc_pkg::STATUS_CRC_BAD;
      end else if (address_ff != slave_address_ff || function_ff != function_code_ff) begin
         status_in = rfc_pkg::STATUS_MISMATCH;
      end else if (count_byte_ff[0] ||
                   length_ff != {2'b00, count_byte_ff} + rfc_pkg::FRAME_OVERHEAD) begin
         status_in = rfc_pkg::STATUS_COUNT_BAD;
      end else if (count_full > limit) begin
         status_in = rfc_pkg::STATUS_TOO_MANY;
      end else begin
         status_in = rfc_pkg::STATUS_OK;
      end
   end

   // Read address: entry 0 at the check, then one ahead of each load
   assign k_next  = k_ff + 6'd1;
   assign rd_en   = cmd.check_en || cmd.load_en;
   assign rd_addr = cmd.check_en ? '0 : k_next[AW-1:0];

   // Latch check result and advance the run index
   always_ff @(posedge clock) begin
      if (cmd.check_en) begin
         status_ff <= status_in;
         count_ff  <= count_full[5:0];
         k_ff      <= '0;
      end else if (cmd.load_en) begin
         k_ff <= k_next;
      end
   end

   assign dp_status.slot_free = !rsp_valid_ff || !rsp_stall;
   assign dp_status.single    = (status_ff != rfc_pkg::STATUS_OK) || (count_ff == 6'd0);
   assign dp_status.run_done  = (k_next == count_ff);

   // Output register: hold while stalled, drop the beat once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_en) begin
         if (dp_status.single) begin
            rsp_data_ff.status         <= status_ff;
            rsp_data_ff.reg_total      <= '0;
            rsp_data_ff.register_index <= '0;
            rsp_data_ff.register_value <= '0;
            rsp_data_ff.value_valid    <= 1'b0;
            rsp_data_ff.run_last       <= 1'b1;
         end else begin
            rsp_data_ff.status         <= rfc_pkg::STATUS_OK;
            rsp_data_ff.reg_total      <= count_ff;
            rsp_data_ff.register_index <= k_ff[4:0];
            rsp_data_ff.register_value <= rd_data_ff;
            rsp_data_ff.value_valid    <= 1'b1;
            rsp_data_ff.run_last       <= dp_status.run_done;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> sv/read_response_frame_checker_top.sv
// Read response frame checker: one frame byte per beat, a CRC-16 check and a run of
// register results per frame. The final byte starts the check; then results are loaded
// one per cycle while the output is taken, from the single store read port.
// Throughput: one byte per cycle within a frame; input stalls from the final byte until
// the last result enters the output register. Reset (synchronous) restores the config
// registers and frame state; the register store is not cleared.
// Depends on rfc_pkg, rfc_ctrl and rfc_datapath.
module read_response_frame_checker_top #(
   parameter int MAX_REGS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rfc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rfc_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [1:0]       csr_addr,
   input  logic [7:0]       csr_wr_data
);

   rfc_pkg::ctl_cmd_type   cmd;
   rfc_pkg::dp_status_type dp_status;

   rfc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_frame_end (req_data.frame_end),
      .req_stall     (req_stall),
      .dp_status     (dp_status),
      .cmd           (cmd)
   );

   rfc_datapath #(
      .MAX_REGS (MAX_REGS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .cmd         (cmd),
      .dp_status   (dp_status),
      .csr_wr_en   (csr_wr_en),
      .csr_addr    (csr_addr),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
